// ===== design/als_pkg.sv =====
// Package with the item types, scan phases and constants of the access log status tally.
`default_nettype none

package als_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         line_outcome;
        logic [62:0]        matched_count;
        logic signed [63:0] byte_total;
        logic               line_last;
    } t_out_item;

    typedef struct packed {
        logic        ok;
        logic [10:0] status_value;
        logic        status_negative;
        logic [62:0] bytes_value;
        logic        bytes_negative;
    } t_line_summary;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_WS_A,
        PH_SIGN_A,
        PH_DIG_A,
        PH_WS_B,
        PH_SIGN_B,
        PH_DIG_B,
        PH_DONE
    } t_phase;

    localparam logic [1:0]  OUT_NONE    = 2'd0;
    localparam logic [1:0]  OUT_COUNTED = 2'd1;
    localparam logic [1:0]  OUT_SUMMED  = 2'd2;
    localparam logic [1:0]  OUT_OTHER   = 2'd3;

    localparam logic        CFG_COUNT_CODE = 1'b0;
    localparam logic        CFG_SUM_CODE   = 1'b1;

    localparam logic [9:0]  COUNT_CODE_RESET = 10'd404;
    localparam logic [9:0]  SUM_CODE_RESET   = 10'd200;

    localparam logic [10:0] STATUS_MAX = 11'd2047;
    localparam logic [62:0] MAG_MAX    = {63{1'b1}};

endpackage

`default_nettype wire

// ===== design/als_scanner.sv =====
// Per-byte line scanner that finds the quote and space and parses the status and byte fields.
`default_nettype none

module als_scanner import als_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_move,
    input  wire t_in_item      i_item,
    output t_line_summary      o_summary
);

    t_phase      r_phase, n_phase;
    logic        r_pq, n_pq;
    logic [10:0] r_sv, n_sv;
    logic        r_sn, n_sn;
    logic [62:0] r_bv, n_bv;
    logic        r_bn, n_bn;

    logic [7:0]  c;
    logic [3:0]  dig;
    logic        is_ws, is_dig, is_sign, is_minus;
    logic [14:0] st_mul;
    logic [66:0] by_mul;
    logic [10:0] st_next;
    logic [62:0] by_next;

    assign c        = i_item.text_byte;
    assign dig      = 4'(c - 8'h30);
    assign is_ws    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    assign is_dig   = (c >= 8'h30) && (c <= 8'h39);
    assign is_sign  = (c == 8'h2B) || (c == 8'h2D);
    assign is_minus = (c == 8'h2D);

    assign st_mul  = ({4'b0, r_sv} << 3) + ({4'b0, r_sv} << 1) + {11'b0, dig};
    assign st_next = (st_mul > {4'b0, STATUS_MAX}) ? STATUS_MAX : st_mul[10:0];
    assign by_mul  = ({4'b0, r_bv} << 3) + ({4'b0, r_bv} << 1) + {63'b0, dig};
    assign by_next = (|by_mul[66:63]) ? MAG_MAX : by_mul[62:0];

    always_comb begin
        n_phase = r_phase;
        n_pq    = r_pq;
        n_sv    = r_sv;
        n_sn    = r_sn;
        n_bv    = r_bv;
        n_bn    = r_bn;
        if (r_phase != PH_DONE) begin
            if (c == 8'h00) begin
                n_phase = PH_DONE;
                n_pq    = (r_phase == PH_DIG_B);
            end else begin
                case (r_phase)
                    PH_SEARCH: begin
                        if (r_pq && c == 8'h20) begin
                            n_phase = PH_WS_A;
                            n_pq    = 1'b0;
                        end else begin
                            n_pq = (c == 8'h22);
                        end
                    end
                    PH_WS_A: begin
                        if (is_ws) begin
                            n_phase = PH_WS_A;
                        end else if (is_sign) begin
                            n_sn    = is_minus;
                            n_phase = PH_SIGN_A;
                        end else if (is_dig) begin
                            n_sv    = st_next;
                            n_phase = PH_DIG_A;
                        end else begin
                            n_phase = PH_DONE;
                            n_pq    = 1'b0;
                        end
                    end
                    PH_SIGN_A: begin
                        if (is_dig) begin
                            n_sv    = st_next;
                            n_phase = PH_DIG_A;
                        end else begin
                            n_phase = PH_DONE;
                            n_pq    = 1'b0;
                        end
                    end
                    PH_DIG_A: begin
                        if (is_dig) begin
                            n_sv = st_next;
                        end else if (is_ws) begin
                            n_phase = PH_WS_B;
                        end else if (is_sign) begin
                            n_bn    = is_minus;
                            n_phase = PH_SIGN_B;
                        end else begin
                            n_phase = PH_DONE;
                            n_pq    = 1'b0;
                        end
                    end
                    PH_WS_B: begin
                        if (is_ws) begin
                            n_phase = PH_WS_B;
                        end else if (is_sign) begin
                            n_bn    = is_minus;
                            n_phase = PH_SIGN_B;
                        end else if (is_dig) begin
                            n_bv    = by_next;
                            n_phase = PH_DIG_B;
                        end else begin
                            n_phase = PH_DONE;
                            n_pq    = 1'b0;
                        end
                    end
                    PH_SIGN_B: begin
                        if (is_dig) begin
                            n_bv    = by_next;
                            n_phase = PH_DIG_B;
                        end else begin
                            n_phase = PH_DONE;
                            n_pq    = 1'b0;
                        end
                    end
                    PH_DIG_B: begin
                        if (is_dig) begin
                            n_bv = by_next;
                        end else begin
                            n_phase = PH_DONE;
                            n_pq    = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    assign o_summary.ok              = (n_phase == PH_DIG_B) || (n_phase == PH_DONE && n_pq);
    assign o_summary.status_value    = n_sv;
    assign o_summary.status_negative = n_sn;
    assign o_summary.bytes_value     = n_bv;
    assign o_summary.bytes_negative  = n_bn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_move && i_item.line_end)) begin
            r_phase <= PH_SEARCH;
            r_pq    <= 1'b0;
            r_sv    <= '0;
            r_sn    <= 1'b0;
            r_bv    <= '0;
            r_bn    <= 1'b0;
        end else if (i_move) begin
            r_phase <= n_phase;
            r_pq    <= n_pq;
            r_sv    <= n_sv;
            r_sn    <= n_sn;
            r_bv    <= n_bv;
            r_bn    <= n_bn;
        end
    end

endmodule

`default_nettype wire

// ===== design/als_tally.sv =====
// Status matching, saturating totals, configuration registers and the result register.
`default_nettype none

module als_tally import als_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [9:0]    i_cfg_data,
    input  wire logic          i_move,
    input  wire t_line_summary i_summary,
    output t_out_item          o_item
);

    logic [9:0]         r_count_code;
    logic [9:0]         r_sum_code;
    logic [62:0]        r_count;
    logic signed [63:0] r_total;
    t_out_item          r_item;

    logic               count_hit, sum_hit, neg_nonzero;
    logic [62:0]        n_count;
    logic signed [63:0] n_total;
    logic [1:0]         n_outcome;
    logic [64:0]        addend, total_ext, sum65;

    assign neg_nonzero = i_summary.status_negative && (i_summary.status_value != 11'd0);
    assign count_hit   = !neg_nonzero && (i_summary.status_value == {1'b0, r_count_code});
    assign sum_hit     = !neg_nonzero && (i_summary.status_value == {1'b0, r_sum_code});

    assign addend    = i_summary.bytes_negative ? ~{2'b00, i_summary.bytes_value}
                                                : {2'b00, i_summary.bytes_value};
    assign total_ext = {r_total[63], r_total};
    assign sum65     = total_ext + addend + {64'b0, i_summary.bytes_negative};

    always_comb begin
        n_count   = r_count;
        n_total   = r_total;
        n_outcome = OUT_NONE;
        if (i_summary.ok) begin
            if (count_hit) begin
                n_outcome = OUT_COUNTED;
                if (r_count != MAG_MAX) begin
                    n_count = r_count + 63'd1;
                end
            end else if (sum_hit) begin
                n_outcome = OUT_SUMMED;
                if (sum65[64] != sum65[63]) begin
                    n_total = sum65[64] ? {1'b1, 63'b0} : {1'b0, MAG_MAX};
                end else begin
                    n_total = sum65[63:0];
                end
            end else begin
                n_outcome = OUT_OTHER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_code <= COUNT_CODE_RESET;
            r_sum_code   <= SUM_CODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COUNT_CODE: r_count_code <= i_cfg_data;
                CFG_SUM_CODE:   r_sum_code   <= i_cfg_data;
                default:        r_sum_code   <= r_sum_code;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_move) begin
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_item.line_outcome  <= n_outcome;
            r_item.matched_count <= n_count;
            r_item.byte_total    <= n_total;
            r_item.line_last     <= 1'b1;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== design/access_log_status_tally.sv =====
// Top level of the access log status tally: handshake pipeline around scanner and tally.
//
// The block takes one log byte per cycle and never stalls on input while the
// scanner has bytes that do not end a line; throughput is one item per clock,
// set by the scanner's per-byte multiply-by-ten accumulate into the 63-bit
// byte field. A line's result passes from the input register, where its last
// byte is accepted, through the line summary register and then to the result
// register. Only a line end can be held back, and only while both the summary
// and the result registers are full and the result is not being taken.
// Configuration writes are always accepted and must be made while the block
// is idle.
`default_nettype none

module access_log_status_tally import als_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [9:0] i_cfg_data
);

    logic          r_in_valid;
    t_in_item      r_in_item;
    logic          r_sum_valid;
    t_line_summary r_sum;
    logic          r_out_valid;
    t_line_summary summary;

    logic out_free, sum_move, sum_free, in_move, in_free;

    assign out_free = !r_out_valid || i_out_ready;
    assign sum_move = r_sum_valid && out_free;
    assign sum_free = !r_sum_valid || out_free;
    assign in_move  = r_in_valid && (!r_in_item.line_end || sum_free);
    assign in_free  = !r_in_valid || in_move;

    assign o_in_ready  = in_free;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    als_scanner u_scanner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_move    (in_move),
        .i_item    (r_in_item),
        .o_summary (summary)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (sum_free) begin
            r_sum_valid <= in_move && r_in_item.line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_free && in_move && r_in_item.line_end) begin
            r_sum <= summary;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= sum_move;
        end
    end

    als_tally u_tally (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_move      (sum_move),
        .i_summary   (r_sum),
        .o_item      (o_out_item)
    );

    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_valid && !out_free |=> r_sum_valid && $stable(r_sum))
        else $error("Line summary changed while stalled.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_move |=> r_out_valid)
        else $error("Line summary moved without a result.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_in_item.line_end && r_sum_valid && r_out_valid)
        else $error("Input stalled without a full pipeline.");

    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_out_item.line_last)
        else $error("Result item without line_last.");

endmodule

`default_nettype wire

// ===== bench/tb_access_log_status_tally.sv =====
// Testbench for the access log status tally with a line-level predictor and result checker.
`default_nettype none

module tb_access_log_status_tally;
    import als_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] SPACE_SET [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_LO = -SUM_HI - 65'sd1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_index = CFG_COUNT_CODE;
    logic [9:0] cfg_data = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       o_cfg_ready;

    access_log_status_tally dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial begin
        #4000000;
        $display("access_log_status_tally regression: fail");
        $finish;
    end

    t_phase             scan_ph;
    logic               quote_seen;
    logic [10:0]        stat_mag;
    logic               stat_neg;
    logic [62:0]        field_mag;
    logic               field_neg;
    logic [62:0]        lines_counted;
    logic signed [63:0] bytes_summed;
    logic [9:0]         tally_count_code;
    logic [9:0]         tally_sum_code;

    t_out_item   expected_totals[$];
    logic [7:0]  line_buf[$];
    int          mismatch_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          stall_left = 0;
    t_out_item   want;

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sign(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic void clear_line_state();
        scan_ph = PH_SEARCH;
        quote_seen = 1'b0;
        stat_mag = '0;
        stat_neg = 1'b0;
        field_mag = '0;
        field_neg = 1'b0;
    endfunction

    function automatic void finish_parse(input bit ok);
        scan_ph = PH_DONE;
        quote_seen = ok;
    endfunction

    function automatic void push_status_digit(input logic [7:0] c);
        logic [14:0] v;
        v = 15'(stat_mag) * 15'd10 + 15'(c - CH_ZERO);
        stat_mag = (v > 15'(STATUS_MAX)) ? STATUS_MAX : v[10:0];
    endfunction

    function automatic void push_field_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if ({1'b0, field_mag} > (64'(MAG_MAX) - d) / 64'd10)
            field_mag = MAG_MAX;
        else
            field_mag = 63'({1'b0, field_mag} * 64'd10 + d);
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        if (scan_ph == PH_DONE)
            return;
        if (c == CH_NUL) begin
            finish_parse(scan_ph == PH_DIG_B);
            return;
        end
        case (scan_ph)
            PH_SEARCH: begin
                if (quote_seen && c == CH_SPACE) begin
                    scan_ph = PH_WS_A;
                    quote_seen = 1'b0;
                end else begin
                    quote_seen = (c == CH_QUOTE);
                end
            end
            PH_WS_A: begin
                if (!is_space(c)) begin
                    if (is_sign(c)) begin
                        stat_neg = (c == CH_MINUS);
                        scan_ph = PH_SIGN_A;
                    end else if (is_digit(c)) begin
                        push_status_digit(c);
                        scan_ph = PH_DIG_A;
                    end else begin
                        finish_parse(1'b0);
                    end
                end
            end
            PH_SIGN_A: begin
                if (is_digit(c)) begin
                    push_status_digit(c);
                    scan_ph = PH_DIG_A;
                end else begin
                    finish_parse(1'b0);
                end
            end
            PH_DIG_A: begin
                if (is_digit(c)) begin
                    push_status_digit(c);
                end else if (is_space(c)) begin
                    scan_ph = PH_WS_B;
                end else if (is_sign(c)) begin
                    field_neg = (c == CH_MINUS);
                    scan_ph = PH_SIGN_B;
                end else begin
                    finish_parse(1'b0);
                end
            end
            PH_WS_B: begin
                if (!is_space(c)) begin
                    if (is_sign(c)) begin
                        field_neg = (c == CH_MINUS);
                        scan_ph = PH_SIGN_B;
                    end else if (is_digit(c)) begin
                        push_field_digit(c);
                        scan_ph = PH_DIG_B;
                    end else begin
                        finish_parse(1'b0);
                    end
                end
            end
            PH_SIGN_B: begin
                if (is_digit(c)) begin
                    push_field_digit(c);
                    scan_ph = PH_DIG_B;
                end else begin
                    finish_parse(1'b0);
                end
            end
            default: begin
                if (is_digit(c))
                    push_field_digit(c);
                else
                    finish_parse(1'b1);
            end
        endcase
    endfunction

    function automatic bit status_matches(input logic [9:0] code);
        if (stat_neg && stat_mag != '0)
            return 1'b0;
        return stat_mag == {1'b0, code};
    endfunction

    function automatic void add_field_to_sum();
        logic signed [64:0] v;
        logic signed [64:0] s;
        v = $signed({2'b00, field_mag});
        if (field_neg)
            v = -v;
        s = $signed({bytes_summed[63], bytes_summed}) + v;
        if (s > SUM_HI)
            bytes_summed = SUM_HI[63:0];
        else if (s < SUM_LO)
            bytes_summed = SUM_LO[63:0];
        else
            bytes_summed = s[63:0];
    endfunction

    function automatic t_out_item close_line();
        t_out_item r;
        logic      ok;
        ok = (scan_ph == PH_DIG_B) || (scan_ph == PH_DONE && quote_seen);
        r.line_outcome = OUT_NONE;
        if (ok) begin
            if (status_matches(tally_count_code)) begin
                if (lines_counted != MAG_MAX)
                    lines_counted = lines_counted + 63'd1;
                r.line_outcome = OUT_COUNTED;
            end else if (status_matches(tally_sum_code)) begin
                add_field_to_sum();
                r.line_outcome = OUT_SUMMED;
            end else begin
                r.line_outcome = OUT_OTHER;
            end
        end
        clear_line_state();
        r.matched_count = lines_counted;
        r.byte_total = bytes_summed;
        r.line_last = 1'b1;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
            out_ready <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 30);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_totals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: outcome %0d count %0d total %0d last %0d",
                             o_out_item.line_outcome, o_out_item.matched_count,
                             $signed(o_out_item.byte_total), o_out_item.line_last);
            end else begin
                want = expected_totals.pop_front();
                if (o_out_item.line_outcome !== want.line_outcome ||
                    o_out_item.matched_count !== want.matched_count ||
                    o_out_item.byte_total !== want.byte_total ||
                    o_out_item.line_last !== want.line_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: outcome %0d/%0d count %0d/%0d ",
                                  "total %0d/%0d last %0d/%0d (expected/actual)"},
                                 want.line_outcome, o_out_item.line_outcome,
                                 want.matched_count, o_out_item.matched_count,
                                 $signed(want.byte_total), $signed(o_out_item.byte_total),
                                 want.line_last, o_out_item.line_last);
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.text_byte <= c;
        in_item.line_end <= last;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        scan_byte(c);
        if (last)
            expected_totals.push_back(close_line());
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_item(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        add_str(s);
        send_line();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_codes(input logic [9:0] count_code, input logic [9:0] sum_code);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_COUNT_CODE;
        cfg_data <= count_code;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        tally_count_code = count_code;
        cfg_index <= CFG_SUM_CODE;
        cfg_data <= sum_code;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        tally_sum_code = sum_code;
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_digits(input int n);
        repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] pick_sign();
        return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    endfunction

    function automatic void add_good_line(input logic [9:0] cc, input logic [9:0] sc);
        int r;
        repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        add_str("\" ");
        repeat ($urandom_range(0, 2)) line_buf.push_back(SPACE_SET[$urandom_range(0, 5)]);
        if ($urandom_range(0, 99) < 20)
            line_buf.push_back(pick_sign());
        if ($urandom_range(0, 99) < 10)
            line_buf.push_back(CH_ZERO);
        r = $urandom_range(0, 99);
        if (r < 40)
            add_str($sformatf("%0d", cc));
        else if (r < 75)
            add_str($sformatf("%0d", sc));
        else
            add_str($sformatf("%0d", $urandom_range(0, 99999)));
        if ($urandom_range(0, 99) < 15) begin
            line_buf.push_back(pick_sign());
        end else begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(SPACE_SET[$urandom_range(0, 5)]);
            if ($urandom_range(0, 99) < 20)
                line_buf.push_back(pick_sign());
        end
        add_digits(($urandom_range(0, 99) < 6) ? $urandom_range(19, 22) : $urandom_range(1, 7));
        r = $urandom_range(0, 99);
        if (r >= 50) begin
            line_buf.push_back((r < 55) ? CH_NUL : SPACE_SET[$urandom_range(0, 5)]);
            repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_random_line(input logic [9:0] cc, input logic [9:0] sc);
        int r;
        int keep;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            add_good_line(cc, sc);
        end else if (r < 87) begin
            if ($urandom_range(0, 1))
                add_str("\" ");
            repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else if (r < 94) begin
            add_good_line(cc, sc);
            keep = $urandom_range(1, line_buf.size());
            while (line_buf.size() > keep)
                void'(line_buf.pop_back());
        end else begin
            add_good_line(cc, sc);
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic test_basic_lines();
        send_text("a\" 404 17");
        send_text("\" 200 55");
        send_text("\" 200 -30");
        send_text("\"x\" 301\t+7");
        send_text("no quote 200 5");
        send_text("\" +200-3");
        add_str("\" 200 ");
        line_buf.push_back(CH_NUL);
        send_text("5");
        add_str("\" 200 12");
        line_buf.push_back(CH_NUL);
        send_text("9");
        send_text("\" 200");
        send_text("\" 99999 1");
        add_str("\" 200 ");
        line_buf.push_back(8'hFF);
        send_text("3");
        line_buf.push_back(8'h80);
        send_text("\" 200 1 tail");
        send_text("\"");
        send_text("\"  \v200\f\015\n4");
    endtask

    task automatic test_sum_saturation();
        repeat (2) begin
            add_str("\" 200 ");
            repeat (25) line_buf.push_back(CH_NINE);
            send_line();
        end
        repeat (3) begin
            add_str("\" 200 -");
            repeat (25) line_buf.push_back(CH_NINE);
            send_line();
        end
        send_text("\" 200 -1");
        send_text("\" 200 +5");
    endtask

    task automatic test_code_registers();
        settle();
        write_codes(10'd0, 10'd0);
        send_text("\" -0 9");
        send_text("\" 0 3");
        send_text("\" -5 9");
        send_text("\" 00 2");
        settle();
        write_codes(10'd999, 10'd0);
        send_text("\" 999 1");
        send_text("\" -0 -4");
        send_text("\" 1000 1");
        settle();
        write_codes(10'd0, 10'd999);
        send_text("\" 999 6");
        send_text("\" +0 6");
    endtask

    task automatic run_phase(input logic [9:0] cc, input logic [9:0] sc,
                             input bit tx_s, input bit rx_s, input int budget);
        int sent;
        sent = 0;
        settle();
        write_codes(cc, sc);
        tx_steady = tx_s;
        rx_steady = rx_s;
        while (sent < budget) begin
            add_random_line(cc, sc);
            sent += line_buf.size();
            send_line();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [9:0] code;
        code = 10'($urandom_range(0, 999));
        run_phase(10'd0, 10'd999, 1'b0, 1'b0, 270);
        run_phase(10'd999, 10'd0, 1'b1, 1'b1, 270);
        run_phase(10'($urandom_range(0, 999)), 10'($urandom_range(0, 999)), 1'b0, 1'b0, 270);
        run_phase(code, code, 1'b0, 1'b1, 270);
        run_phase(COUNT_CODE_RESET, SUM_CODE_RESET, 1'b1, 1'b0, 270);
    endtask

    initial begin
        tally_count_code = COUNT_CODE_RESET;
        tally_sum_code = SUM_CODE_RESET;
        lines_counted = '0;
        bytes_summed = '0;
        clear_line_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_lines();
        test_sum_saturation();
        test_code_registers();
        test_random_traffic();
        settle();
        if (expected_totals.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("access_log_status_tally regression: pass");
        else
            $display("access_log_status_tally regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/als_pkg.sv
design/als_scanner.sv
design/als_tally.sv
design/access_log_status_tally.sv
bench/tb_access_log_status_tally.sv
